### rtl/soc_pkg.sv
// Package for the sprite overlay compositor.
// Holds the sizing constants, the item structs and the code enums.
// No dependencies.
package soc_pkg;

   localparam int MAX_STICKERS  = 8;
   localparam int SPRITE_SIDE   = 64;
   localparam int COORD_BITS    = 12;

   localparam int IDX_BITS      = $clog2(MAX_STICKERS);
   localparam int CNT_BITS      = $clog2(MAX_STICKERS + 1);
   localparam int SIDE_BITS     = $clog2(SPRITE_SIDE);
   localparam int SIZE_BITS     = $clog2(SPRITE_SIDE + 1);
   localparam int CLR_BITS      = 2 * SIDE_BITS;
   localparam int PIX_ADDR_BITS = IDX_BITS + CLR_BITS;
   localparam int EXT_BITS      = 13;

   localparam logic [11:0] HUE_MAX = 12'd3599;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_LOAD     = 3'd1,
      OP_MOVE     = 3'd2,
      OP_REMOVE   = 3'd3,
      OP_CAPACITY = 3'd4,
      OP_COMPOSE  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_BAD_INDEX = 2'd2,
      STS_CAP_SAT   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_BASE_WIDTH      = 3'd0,
      CSR_BASE_HEIGHT     = 3'd1,
      CSR_FILL_HUE        = 3'd2,
      CSR_FILL_SATURATION = 3'd3,
      CSR_FILL_LIGHTNESS  = 3'd4,
      CSR_FILL_ALPHA      = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOOKUP,
      ST_CLEAR,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [11:0] hue;
      logic [7:0]  saturation;
      logic [7:0]  lightness;
      logic [7:0]  alpha;
   } pixel_type;

   typedef struct packed {
      logic [2:0]            opcode;
      logic [2:0]            sticker_index;
      logic [COORD_BITS-1:0] coord_x;
      logic [COORD_BITS-1:0] coord_y;
      logic [6:0]            sprite_width;
      logic [6:0]            sprite_height;
      logic [7:0]            capacity_request;
      logic [11:0]           hue;
      logic [7:0]            saturation;
      logic [7:0]            lightness;
      logic [7:0]            alpha;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  assigned_index;
      logic [11:0] out_hue;
      logic [7:0]  out_saturation;
      logic [7:0]  out_lightness;
      logic [7:0]  out_alpha;
      logic [12:0] canvas_width;
      logic [12:0] canvas_height;
      logic [3:0]  sprite_count;
   } rsp_type;

endpackage

### rtl/soc_pixel_store.sv
// Sprite pixel memory: one slot of SPRITE_SIDE x SPRITE_SIDE pixels per sprite.
// One write port, one read port, registered read data. Uses soc_pkg.
module soc_pixel_store (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [soc_pkg::PIX_ADDR_BITS-1:0] wr_addr,
   input  soc_pkg::pixel_type                wr_data,
   input  logic                              rd_en,
   input  logic [soc_pkg::PIX_ADDR_BITS-1:0] rd_addr,
   output soc_pkg::pixel_type                rd_data
);

   soc_pkg::pixel_type mem [2**soc_pkg::PIX_ADDR_BITS];
   soc_pkg::pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sprite_overlay_compositor_unit.sv
// Sprite overlay compositor top level: sprite table, sequencer, result register.
// Uses soc_pkg and soc_pixel_store.
//
// One item gives one result. The sequencer walks the table one entry a
// cycle to find the canvas extent and, on compose, to read the pixel store
// once for each covering sprite. An accepted add also first clears the new
// sprite's pixel slot of SPRITE_SIDE*SPRITE_SIDE (4096) pixels, one pixel a
// cycle. A finished result waits in its own register while the next item is
// taken.
module sprite_overlay_compositor_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  soc_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output soc_pkg::rsp_type rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [12:0]      csr_data
);

   localparam int MAXS = soc_pkg::MAX_STICKERS;
   localparam int IB   = soc_pkg::IDX_BITS;
   localparam int CB   = soc_pkg::CNT_BITS;
   localparam int SB   = soc_pkg::SIDE_BITS;
   localparam int ZB   = soc_pkg::SIZE_BITS;
   localparam int XB   = soc_pkg::COORD_BITS;
   localparam int EB   = soc_pkg::EXT_BITS;

   soc_pkg::state_type state_ff, state_in;
   soc_pkg::req_type   req_ff, req_in;
   logic [CB-1:0]      ptr_ff, ptr_in;
   logic [CB-1:0]      used_ff, used_in;
   logic [CB-1:0]      cap_ff, cap_in;
   logic [MAXS-1:0]    busy_ff, busy_in;
   logic [IB-1:0]      ent_slot_ff [MAXS];
   logic [IB-1:0]      ent_slot_in [MAXS];
   logic [XB-1:0]      ent_x_ff    [MAXS];
   logic [XB-1:0]      ent_x_in    [MAXS];
   logic [XB-1:0]      ent_y_ff    [MAXS];
   logic [XB-1:0]      ent_y_in    [MAXS];
   logic [ZB-1:0]      ent_w_ff    [MAXS];
   logic [ZB-1:0]      ent_w_in    [MAXS];
   logic [ZB-1:0]      ent_h_ff    [MAXS];
   logic [ZB-1:0]      ent_h_in    [MAXS];
   logic [2*SB-1:0]    clr_ff, clr_in;
   logic [IB-1:0]      clr_slot_ff, clr_slot_in;
   logic [1:0]         status_ff, status_in;
   logic [2:0]         assigned_ff, assigned_in;
   logic               hit_ff, hit_in;
   soc_pkg::pixel_type px_ff, px_in;
   logic               pend_ff, pend_in;
   logic [EB-1:0]      cw_ff, cw_in, ch_ff, ch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   soc_pkg::rsp_type   rsp_ff, rsp_in;

   logic [12:0] base_width_ff, base_height_ff;
   logic [11:0] fill_hue_ff;
   logic [7:0]  fill_sat_ff, fill_lig_ff, fill_alpha_ff;

   logic                          mem_we, mem_re;
   logic [soc_pkg::PIX_ADDR_BITS-1:0] mem_waddr, mem_raddr;
   soc_pkg::pixel_type            mem_wdata, mem_rdata;

   soc_pixel_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_width_ff  <= '0;
         base_height_ff <= '0;
         fill_hue_ff    <= '0;
         fill_sat_ff    <= '0;
         fill_lig_ff    <= 8'd255;
         fill_alpha_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            soc_pkg::CSR_BASE_WIDTH:      base_width_ff  <= csr_data;
            soc_pkg::CSR_BASE_HEIGHT:     base_height_ff <= csr_data;
            soc_pkg::CSR_FILL_HUE:        fill_hue_ff    <= csr_data[11:0];
            soc_pkg::CSR_FILL_SATURATION: fill_sat_ff    <= csr_data[7:0];
            soc_pkg::CSR_FILL_LIGHTNESS:  fill_lig_ff    <= csr_data[7:0];
            soc_pkg::CSR_FILL_ALPHA:      fill_alpha_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // current table entry under the pointer
   logic [IB-1:0]   cur;
   logic [IB-1:0]   e_slot;
   logic [XB-1:0]   e_x, e_y, dx, dy;
   logic [ZB-1:0]   e_w, e_h;
   logic            covers;
   logic [EB-1:0]   e_r, e_b, acc_w, acc_h;
   logic            idx_ok;
   logic            free_found;
   logic [IB-1:0]   free_slot;
   logic [CB-1:0]   new_cap;
   logic [7:0]      cap_req;
   soc_pkg::pixel_type sel_px, wr_px;
   logic            in_base;

   assign cur    = ptr_ff[IB-1:0];
   assign e_slot = ent_slot_ff[cur];
   assign e_x    = ent_x_ff[cur];
   assign e_y    = ent_y_ff[cur];
   assign e_w    = ent_w_ff[cur];
   assign e_h    = ent_h_ff[cur];
   assign dx     = req_ff.coord_x - e_x;
   assign dy     = req_ff.coord_y - e_y;
   assign covers = (req_ff.coord_x >= e_x) && (32'(dx) < 32'(e_w)) &&
                   (req_ff.coord_y >= e_y) && (32'(dy) < 32'(e_h));
   assign e_r    = EB'(e_x) + EB'(e_w);
   assign e_b    = EB'(e_y) + EB'(e_h);
   assign idx_ok = (CB'(req_ff.sticker_index) < used_ff);
   assign cap_req = req_ff.capacity_request;
   assign in_base = (EB'(req_ff.coord_x) < base_width_ff) &&
                    (EB'(req_ff.coord_y) < base_height_ff);

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = 0; i < MAXS; i++) begin
         if (!free_found && !busy_ff[i]) begin
            free_found = 1'b1;
            free_slot  = IB'(i);
         end
      end
   end

   always_comb begin
      new_cap = (32'(cap_req) > MAXS) ? CB'(MAXS) : CB'(cap_req);
   end

   always_comb begin
      wr_px.hue        = req_ff.hue;
      wr_px.saturation = req_ff.saturation;
      wr_px.lightness  = req_ff.lightness;
      wr_px.alpha      = req_ff.alpha;
      if (hit_ff) begin
         sel_px = px_ff;
      end else if (in_base) begin
         sel_px = wr_px;
      end else begin
         sel_px.hue        = fill_hue_ff;
         sel_px.saturation = fill_sat_ff;
         sel_px.lightness  = fill_lig_ff;
         sel_px.alpha      = fill_alpha_ff;
      end
      if (sel_px.hue > soc_pkg::HUE_MAX) begin
         sel_px.hue = soc_pkg::HUE_MAX;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      used_in      = used_ff;
      cap_in       = cap_ff;
      busy_in      = busy_ff;
      ent_slot_in  = ent_slot_ff;
      ent_x_in     = ent_x_ff;
      ent_y_in     = ent_y_ff;
      ent_w_in     = ent_w_ff;
      ent_h_in     = ent_h_ff;
      clr_in       = clr_ff;
      clr_slot_in  = clr_slot_ff;
      status_in    = status_ff;
      assigned_in  = assigned_ff;
      hit_in       = hit_ff;
      px_in        = px_ff;
      pend_in      = 1'b0;
      cw_in        = cw_ff;
      ch_in        = ch_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;
      acc_w        = '0;
      acc_h        = '0;
      req_stall    = 1'b1;

      case (state_ff)
         soc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in   = req_item;
               state_in = soc_pkg::ST_DECODE;
            end
         end

         soc_pkg::ST_DECODE: begin
            status_in   = soc_pkg::STS_OK;
            assigned_in = '0;
            hit_in      = 1'b0;
            ptr_in      = '0;
            state_in    = soc_pkg::ST_SCAN;
            case (req_ff.opcode)
               soc_pkg::OP_ADD: begin
                  if (used_ff >= cap_ff || 32'(used_ff) >= MAXS || !free_found) begin
                     status_in = soc_pkg::STS_FULL;
                  end else begin
                     busy_in[free_slot] = 1'b1;
                     ent_slot_in[used_ff[IB-1:0]] = free_slot;
                     ent_x_in[used_ff[IB-1:0]]    = req_ff.coord_x;
                     ent_y_in[used_ff[IB-1:0]]    = req_ff.coord_y;
                     ent_w_in[used_ff[IB-1:0]]    =
                        (32'(req_ff.sprite_width) > soc_pkg::SPRITE_SIDE) ?
                        ZB'(soc_pkg::SPRITE_SIDE) : ZB'(req_ff.sprite_width);
                     ent_h_in[used_ff[IB-1:0]]    =
                        (32'(req_ff.sprite_height) > soc_pkg::SPRITE_SIDE) ?
                        ZB'(soc_pkg::SPRITE_SIDE) : ZB'(req_ff.sprite_height);
                     assigned_in = 3'(used_ff);
                     used_in     = used_ff + 1'b1;
                     clr_in      = '0;
                     clr_slot_in = free_slot;
                     state_in    = soc_pkg::ST_CLEAR;
                  end
               end
               soc_pkg::OP_LOAD, soc_pkg::OP_REMOVE: begin
                  if (!idx_ok) begin
                     status_in = soc_pkg::STS_BAD_INDEX;
                  end else begin
                     ptr_in   = CB'(req_ff.sticker_index);
                     state_in = soc_pkg::ST_LOOKUP;
                  end
               end
               soc_pkg::OP_MOVE: begin
                  if (!idx_ok) begin
                     status_in = soc_pkg::STS_BAD_INDEX;
                  end else begin
                     ent_x_in[req_ff.sticker_index[IB-1:0]] = req_ff.coord_x;
                     ent_y_in[req_ff.sticker_index[IB-1:0]] = req_ff.coord_y;
                  end
               end
               soc_pkg::OP_CAPACITY: begin
                  if (32'(cap_req) > MAXS) begin
                     status_in = soc_pkg::STS_CAP_SAT;
                  end
                  cap_in = new_cap;
                  for (int i = 0; i < MAXS; i++) begin
                     if (CB'(i) >= new_cap && CB'(i) < used_ff) begin
                        busy_in[ent_slot_ff[i]] = 1'b0;
                     end
                  end
                  if (used_ff > new_cap) begin
                     used_in = new_cap;
                  end
               end
               default: ;
            endcase
         end

         soc_pkg::ST_LOOKUP: begin
            if (req_ff.opcode == soc_pkg::OP_LOAD) begin
               if (32'(req_ff.coord_x) < 32'(e_w) && 32'(req_ff.coord_y) < 32'(e_h)) begin
                  mem_we    = 1'b1;
                  mem_waddr = {e_slot, req_ff.coord_y[SB-1:0], req_ff.coord_x[SB-1:0]};
                  mem_wdata = wr_px;
               end else begin
                  status_in = soc_pkg::STS_BAD_INDEX;
               end
            end else begin
               busy_in[e_slot] = 1'b0;
               for (int i = 0; i < MAXS - 1; i++) begin
                  if (CB'(i) >= ptr_ff) begin
                     ent_slot_in[i] = ent_slot_ff[i+1];
                     ent_x_in[i]    = ent_x_ff[i+1];
                     ent_y_in[i]    = ent_y_ff[i+1];
                     ent_w_in[i]    = ent_w_ff[i+1];
                     ent_h_in[i]    = ent_h_ff[i+1];
                  end
               end
               used_in = used_ff - 1'b1;
            end
            ptr_in   = '0;
            state_in = soc_pkg::ST_SCAN;
         end

         soc_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = {clr_slot_ff, clr_ff};
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               ptr_in   = '0;
               state_in = soc_pkg::ST_SCAN;
            end
         end

         soc_pkg::ST_SCAN: begin
            // pixel read issued last cycle; later sprites win
            if (pend_ff && mem_rdata.alpha != 8'd0) begin
               hit_in = 1'b1;
               px_in  = mem_rdata;
            end
            acc_w = (ptr_ff == '0) ? base_width_ff  : cw_ff;
            acc_h = (ptr_ff == '0) ? base_height_ff : ch_ff;
            if (ptr_ff < used_ff) begin
               cw_in  = (e_r > acc_w) ? e_r : acc_w;
               ch_in  = (e_b > acc_h) ? e_b : acc_h;
               ptr_in = ptr_ff + 1'b1;
               if (req_ff.opcode == soc_pkg::OP_COMPOSE && covers) begin
                  mem_re    = 1'b1;
                  mem_raddr = {e_slot, dy[SB-1:0], dx[SB-1:0]};
                  pend_in   = 1'b1;
               end
            end else begin
               cw_in    = acc_w;
               ch_in    = acc_h;
               state_in = soc_pkg::ST_FINISH;
            end
         end

         soc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.assigned_index = assigned_ff;
               rsp_in.canvas_width   = cw_ff;
               rsp_in.canvas_height  = ch_ff;
               rsp_in.sprite_count   = 4'(used_ff);
               if (req_ff.opcode == soc_pkg::OP_COMPOSE) begin
                  rsp_in.out_hue        = sel_px.hue;
                  rsp_in.out_saturation = sel_px.saturation;
                  rsp_in.out_lightness  = sel_px.lightness;
                  rsp_in.out_alpha      = sel_px.alpha;
               end else begin
                  rsp_in.out_hue        = '0;
                  rsp_in.out_saturation = '0;
                  rsp_in.out_lightness  = '0;
                  rsp_in.out_alpha      = '0;
               end
               state_in = soc_pkg::ST_IDLE;
            end
         end

         default: state_in = soc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= soc_pkg::ST_IDLE;
         used_ff      <= '0;
         cap_ff       <= CB'(MAXS);
         busy_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cap_ff       <= cap_in;
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      ptr_ff      <= ptr_in;
      ent_slot_ff <= ent_slot_in;
      ent_x_ff    <= ent_x_in;
      ent_y_ff    <= ent_y_in;
      ent_w_ff    <= ent_w_in;
      ent_h_ff    <= ent_h_in;
      clr_ff      <= clr_in;
      clr_slot_ff <= clr_slot_in;
      status_ff   <= status_in;
      assigned_ff <= assigned_in;
      hit_ff      <= hit_in;
      px_ff       <= px_in;
      cw_ff       <= cw_in;
      ch_ff       <= ch_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_used_within_cap: assert property (@(posedge clock) disable iff (reset)
      used_ff <= cap_ff) else $error("sprite count above capacity");

   a_slots_match_count: assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) == 32'(used_ff)) else $error("busy slots out of step with count");

   a_clear_busy_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == soc_pkg::ST_CLEAR |-> busy_ff[clr_slot_ff])
      else $error("clearing a free slot");

   a_read_only_compose: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> req_ff.opcode == soc_pkg::OP_COMPOSE)
      else $error("pixel read outside compose");

endmodule
